@@ design/oas_pkg.sv @@
// ---------------------------------------------------------------------------
// Offset auto-zero sequencer package
// Shared constants, configuration register indexes and the result beat
// layout for the offset auto-zero sequencer.
// ---------------------------------------------------------------------------
package oas_pkg;

  // Configuration port geometry.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_VBUS_MIN    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DUTY_MARGIN = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PWM_TOP     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_DFF_START   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_DFF_LAST    = 3'd4;

  // Configuration reset values.
  localparam logic [14:0] VBUS_MIN_RST    = 15'd0;
  localparam logic [15:0] DUTY_MARGIN_RST = 16'd3277;
  localparam logic [15:0] PWM_TOP_RST     = 16'd0;
  localparam logic [11:0] DFF_START_RST   = 12'd0;
  localparam logic [11:0] DFF_LAST_RST    = 12'd4095;

  // Best error starts at the largest positive 16-bit value.
  localparam int          ERR_W    = 18;
  localparam logic [ERR_W-1:0] ERR_INIT = 18'd32767;

  // Full scale of a Q0.16 duty value (one).
  localparam logic [16:0] DUTY_ONE = 17'h10000;

  // One result beat.
  typedef struct packed {
    logic [2:0]  phase;
    logic [11:0] current_dac_code;
    logic        comp_reset;
    logic [12:0] dff_code;
    logic [11:0] current_offset;
    logic [11:0] dff_offset;
    logic        save_request;
  } result_t;

endpackage

@@ design/offset_autozero_sequencer.sv @@
// Each accepted tick's beat is registered in the output or the skid register.
// Throughput: one tick per cycle unless stalled; the whole tick update sits between the
// state registers and a two-entry output buffer (output register plus skid register).
// in_stall rises only while both output entries are full.
// Reset (rst, synchronous): phase standby, search and sweep state cleared (best error to
// ERR_INIT), configuration registers at their reset values, output buffer empty.
// ---------------------------------------------------------------------------
// Offset auto-zero sequencer
// Per control tick: checks bus rails and relays, runs a successive
// approximation search of the current-offset DAC code, then sweeps the
// duty-offset DAC code and keeps the code with the least PWM count error.
// ---------------------------------------------------------------------------
module offset_autozero_sequencer
  import oas_pkg::*;
#(
  parameter int DAC_BITS   = 12,
  parameter int OVERSAMPLE = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  // Configuration write port.
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // Tick input channel.
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   start_req,
  input  logic signed [15:0]     vbus_plus,
  input  logic signed [15:0]     vbus_minus,
  input  logic                   relay_open,
  input  logic                   precharge_open,
  input  logic [15:0]            duty_level,
  input  logic [17:0]            pwm_count,
  // Result output channel.
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [2:0]             phase,
  output logic [11:0]            current_dac_code,
  output logic                   comp_reset,
  output logic [12:0]            dff_code,
  output logic [11:0]            current_offset,
  output logic [11:0]            dff_offset,
  output logic                   save_request
);

  // Signed bit index runs from DAC_BITS-1 down to -1.
  localparam int BIDX_W = $clog2(DAC_BITS) + 1;
  // Width of (pwm_top + 1) * OVERSAMPLE.
  localparam int PROD_W = 17 + $clog2(OVERSAMPLE + 1);
  localparam int MAG_W  = (PROD_W > ERR_W) ? PROD_W : ERR_W;

  typedef enum logic [2:0] {
    PH_STANDBY = 3'd0,
    PH_WAIT    = 3'd1,
    PH_ISEARCH = 3'd2,
    PH_DSWEEP  = 3'd3,
    PH_DONE    = 3'd4
  } phase_t;

  // Configuration registers.
  logic [14:0] vbus_min;
  logic [15:0] duty_margin;
  logic [15:0] pwm_top;
  logic [11:0] dff_start;
  logic [11:0] dff_last;

  // Sequencer state.
  phase_t                    phase_reg, phase_reg_next;
  logic [DAC_BITS-1:0]       sar_guess, sar_guess_next;
  logic signed [BIDX_W-1:0]  bit_index, bit_index_next;
  logic                      reset_flag, reset_flag_next;
  logic [12:0]               dff_counter, dff_counter_next;
  logic [ERR_W-1:0]          best_error, best_error_next;
  logic [11:0]               best_code, best_code_next;
  logic [11:0]               current_result, current_result_next;
  logic [11:0]               dff_result, dff_result_next;
  logic                      save_next;

  // Output buffer: main register and skid register.
  result_t out_buf, skid_buf, result;
  logic    skid_valid;

  logic in_acc, out_acc;
  logic cond_ok, duty_high, duty_low;
  phase_t ph_a;
  logic [DAC_BITS-1:0]      bit_cur, bit_low;
  logic signed [BIDX_W-1:0] bit_dec;
  logic [DAC_BITS+11:0]     guess_ext;
  logic [DAC_BITS+11:0]     guess_next_ext;
  logic [PROD_W-1:0]        period_os;
  logic [MAG_W-1:0]         half, cnt_ext, err;

  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign in_stall = skid_valid;

  // Rail and relay conditions.
  assign cond_ok = (vbus_plus > $signed({1'b0, vbus_min}))
                && ($signed({vbus_minus[15], vbus_minus}) < -$signed({2'b00, vbus_min}))
                && relay_open && precharge_open;

  // Duty saturation detection.
  assign duty_high = {1'b0, duty_level} > (DUTY_ONE - {1'b0, duty_margin});
  assign duty_low  = duty_level < duty_margin;

  // Bit masks for the bit under test and the next lower bit.
  assign bit_dec = bit_index - BIDX_W'(1);
  assign bit_cur = {{(DAC_BITS-1){1'b0}}, 1'b1} << bit_index[BIDX_W-2:0];
  assign bit_low = {{(DAC_BITS-1){1'b0}}, 1'b1} << bit_dec[BIDX_W-2:0];

  // Guess seen through a 12-bit window, whatever DAC_BITS is.
  assign guess_ext      = {12'd0, sar_guess};
  assign guess_next_ext = {12'd0, sar_guess_next};

  // PWM count error against half of the oversampled period.
  assign period_os = PROD_W'({1'b0, pwm_top} + 17'd1) * PROD_W'(OVERSAMPLE);
  assign half      = MAG_W'(period_os >> 1);
  assign cnt_ext   = MAG_W'(pwm_count);
  assign err       = (cnt_ext >= half) ? (cnt_ext - half) : (half - cnt_ext);

  // Tick update.
  always_comb begin
    sar_guess_next      = sar_guess;
    bit_index_next      = bit_index;
    reset_flag_next     = reset_flag;
    dff_counter_next    = dff_counter;
    best_error_next     = best_error;
    best_code_next      = best_code;
    current_result_next = current_result;
    dff_result_next     = dff_result;
    save_next           = 1'b0;

    // A start request arms standby; failed conditions drop back unless done.
    ph_a = phase_reg;
    if (phase_reg == PH_STANDBY && start_req) begin
      ph_a = PH_WAIT;
    end
    if (!cond_ok && ph_a != PH_DONE) begin
      ph_a = PH_STANDBY;
    end
    phase_reg_next = ph_a;

    unique case (ph_a)
      PH_STANDBY: begin
      end
      PH_WAIT: begin
        if (cond_ok) begin
          phase_reg_next  = PH_ISEARCH;
          bit_index_next  = BIDX_W'(DAC_BITS - 1);
          sar_guess_next  = {1'b1, {(DAC_BITS-1){1'b0}}};
          reset_flag_next = 1'b1;
        end
      end
      PH_ISEARCH: begin
        if (!bit_index[BIDX_W-1]) begin
          if (reset_flag) begin
            reset_flag_next = 1'b0;
          end else if (duty_high || duty_low) begin
            // High saturation clears the bit under test; low keeps it.
            sar_guess_next = duty_high ? (sar_guess & ~bit_cur) : sar_guess;
            bit_index_next = bit_dec;
            if (!bit_dec[BIDX_W-1]) begin
              sar_guess_next  = sar_guess_next | bit_low;
              reset_flag_next = 1'b1;
            end
          end
        end else begin
          // Search exhausted: latch the result and start the sweep.
          current_result_next = guess_ext[11:0];
          phase_reg_next      = PH_DSWEEP;
          dff_counter_next    = {1'b0, dff_start};
          best_error_next     = ERR_INIT;
          reset_flag_next     = 1'b1;
        end
      end
      PH_DSWEEP: begin
        if (err < MAG_W'(best_error)) begin
          best_error_next = err[ERR_W-1:0];
          best_code_next  = dff_counter[11:0];
        end
        dff_counter_next = dff_counter + 13'd1;
        if (dff_counter_next > {1'b0, dff_last}) begin
          dff_result_next = best_code_next;
          phase_reg_next  = PH_DONE;
          save_next       = 1'b1;
        end
      end
      PH_DONE: begin
      end
      default: begin
        phase_reg_next = PH_STANDBY;
      end
    endcase
  end

  // Result beat for this tick.
  always_comb begin
    result.phase            = phase_reg_next;
    result.current_dac_code = guess_next_ext[11:0];
    result.comp_reset       = reset_flag_next;
    result.dff_code         = dff_counter_next;
    result.current_offset   = current_result_next;
    result.dff_offset       = dff_result_next;
    result.save_request     = save_next;
  end

  // State, configuration and output buffer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      vbus_min       <= VBUS_MIN_RST;
      duty_margin    <= DUTY_MARGIN_RST;
      pwm_top        <= PWM_TOP_RST;
      dff_start      <= DFF_START_RST;
      dff_last       <= DFF_LAST_RST;
      phase_reg      <= PH_STANDBY;
      sar_guess      <= '0;
      bit_index      <= '0;
      reset_flag     <= 1'b0;
      dff_counter    <= '0;
      best_error     <= ERR_INIT;
      best_code      <= '0;
      current_result <= '0;
      dff_result     <= '0;
      out_valid      <= 1'b0;
      skid_valid     <= 1'b0;
    end else begin
      // Configuration writes; unknown indexes are ignored.
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_VBUS_MIN:    vbus_min    <= cfg_data[14:0];
          CFG_DUTY_MARGIN: duty_margin <= cfg_data;
          CFG_PWM_TOP:     pwm_top     <= cfg_data;
          CFG_DFF_START:   dff_start   <= cfg_data[11:0];
          CFG_DFF_LAST:    dff_last    <= cfg_data[11:0];
          default: begin
          end
        endcase
      end

      if (in_acc) begin
        phase_reg      <= phase_reg_next;
        sar_guess      <= sar_guess_next;
        bit_index      <= bit_index_next;
        reset_flag     <= reset_flag_next;
        dff_counter    <= dff_counter_next;
        best_error     <= best_error_next;
        best_code      <= best_code_next;
        current_result <= current_result_next;
        dff_result     <= dff_result_next;
      end

      // Output register refills from the skid entry or from a new beat.
      if (!out_valid || out_acc) begin
        if (skid_valid) begin
          out_buf    <= skid_buf;
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_buf   <= result;
          out_valid <= in_acc;
        end
      end else if (in_acc) begin
        skid_buf   <= result;
        skid_valid <= 1'b1;
      end
    end
  end

  assign phase            = out_buf.phase;
  assign current_dac_code = out_buf.current_dac_code;
  assign comp_reset       = out_buf.comp_reset;
  assign dff_code         = out_buf.dff_code;
  assign current_offset   = out_buf.current_offset;
  assign dff_offset       = out_buf.dff_offset;
  assign save_request     = out_buf.save_request;

endmodule

@@ verif/tb.sv @@
// ---------------------------------------------------------------------------
// Offset auto-zero sequencer testbench
// Drives control ticks into the sequencer and checks every result beat
// against a cycle-free model of the calibration sequence. Directed ticks cover
// the rail and relay checks and each search step. Random runs then take the
// search and the sweep deep, and a last run completes one calibration.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import oas_pkg::*;

  localparam int DAC_BITS      = 12;
  localparam int OVERSAMPLE    = 4;
  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT   = 400000;

  // Calibration phase codes as seen on the phase output.
  localparam logic [2:0] PH_STANDBY = 3'd0;
  localparam logic [2:0] PH_WAIT    = 3'd1;
  localparam logic [2:0] PH_SEARCH  = 3'd2;
  localparam logic [2:0] PH_SWEEP   = 3'd3;
  localparam logic [2:0] PH_DONE    = 3'd4;

  // One control tick as carried by the input channel.
  typedef struct {
    logic               start_req;
    logic signed [15:0] vbus_plus;
    logic signed [15:0] vbus_minus;
    logic               relay_open;
    logic               precharge_open;
    logic [15:0]        duty_level;
    logic [17:0]        pwm_count;
  } tick_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   start_req = 1'b0;
  logic signed [15:0]     vbus_plus = '0;
  logic signed [15:0]     vbus_minus = '0;
  logic                   relay_open = 1'b0;
  logic                   precharge_open = 1'b0;
  logic [15:0]            duty_level = '0;
  logic [17:0]            pwm_count = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [2:0]             phase;
  logic [11:0]            current_dac_code;
  logic                   comp_reset;
  logic [12:0]            dff_code;
  logic [11:0]            current_offset;
  logic [11:0]            dff_offset;
  logic                   save_request;

  offset_autozero_sequencer DUT (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .start_req        (start_req),
    .vbus_plus        (vbus_plus),
    .vbus_minus       (vbus_minus),
    .relay_open       (relay_open),
    .precharge_open   (precharge_open),
    .duty_level       (duty_level),
    .pwm_count        (pwm_count),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .phase            (phase),
    .current_dac_code (current_dac_code),
    .comp_reset       (comp_reset),
    .dff_code         (dff_code),
    .current_offset   (current_offset),
    .dff_offset       (dff_offset),
    .save_request     (save_request)
  );

  always #10 clk = ~clk;

  // Model copy of the configuration registers.
  logic [14:0] rail_min;
  logic [15:0] sat_margin;
  logic [15:0] period_top;
  logic [11:0] sweep_first;
  logic [11:0] sweep_last;

  // Model copy of the calibration state.
  logic [2:0]       cal_phase;
  logic [11:0]      sar_code;
  int               sar_bit;
  logic             reset_pulse;
  logic [12:0]      sweep_code;
  logic [ERR_W-1:0] least_err;
  logic [11:0]      least_code;
  logic [11:0]      current_cal;
  logic [11:0]      duty_cal;

  result_t expected_beats[$];
  int      mismatches = 0;
  int      cycle_count = 0;
  int      src_idle_pct = 0;
  int      snk_idle_pct = 0;

  function automatic void reset_calibration_model();
    rail_min    = VBUS_MIN_RST;
    sat_margin  = DUTY_MARGIN_RST;
    period_top  = PWM_TOP_RST;
    sweep_first = DFF_START_RST;
    sweep_last  = DFF_LAST_RST;
    cal_phase   = PH_STANDBY;
    sar_code    = '0;
    sar_bit     = 0;
    reset_pulse = 1'b0;
    sweep_code  = '0;
    least_err   = ERR_INIT;
    least_code  = '0;
    current_cal = '0;
    duty_cal    = '0;
  endfunction

  // Advances the calibration by one tick and returns the beat it produces.
  function automatic result_t advance_calibration(tick_t t);
    result_t beat;
    logic    rails_ok;
    logic    save;
    longint  half;
    longint  diff;
    longint  err;
    save = 1'b0;
    if (cal_phase == PH_STANDBY && t.start_req) begin
      cal_phase = PH_WAIT;
    end
    rails_ok = (int'(t.vbus_plus) > int'(rail_min)) && (int'(t.vbus_minus) < -int'(rail_min))
               && t.relay_open && t.precharge_open;
    if (!rails_ok && cal_phase != PH_DONE) begin
      cal_phase = PH_STANDBY;
    end
    case (cal_phase)
      PH_WAIT: begin
        if (rails_ok) begin
          cal_phase         = PH_SEARCH;
          sar_bit           = DAC_BITS - 1;
          sar_code          = '0;
          sar_code[sar_bit] = 1'b1;
          reset_pulse       = 1'b1;
        end
      end
      PH_SEARCH: begin
        if (sar_bit >= 0) begin
          if (reset_pulse) begin
            reset_pulse = 1'b0;
          end else if (int'(t.duty_level) > 65536 - int'(sat_margin)) begin
            // Saturated high: the bit under test overshoots, drop it.
            sar_code[sar_bit] = 1'b0;
            sar_bit--;
            if (sar_bit >= 0) begin
              sar_code[sar_bit] = 1'b1;
              reset_pulse       = 1'b1;
            end
          end else if (int'(t.duty_level) < int'(sat_margin)) begin
            // Saturated low: the bit stays.
            sar_bit--;
            if (sar_bit >= 0) begin
              sar_code[sar_bit] = 1'b1;
              reset_pulse       = 1'b1;
            end
          end
        end else begin
          current_cal = sar_code;
          cal_phase   = PH_SWEEP;
          sweep_code  = {1'b0, sweep_first};
          least_err   = ERR_INIT;
          reset_pulse = 1'b1;
        end
      end
      PH_SWEEP: begin
        half = (longint'(period_top) + 1) * OVERSAMPLE / 2;
        diff = longint'(t.pwm_count) - half;
        err  = (diff < 0) ? -diff : diff;
        if (err < longint'(least_err)) begin
          least_err  = err[ERR_W-1:0];
          least_code = sweep_code[11:0];
        end
        sweep_code = sweep_code + 13'd1;
        if (sweep_code > {1'b0, sweep_last}) begin
          duty_cal  = least_code;
          cal_phase = PH_DONE;
          save      = 1'b1;
        end
      end
      PH_STANDBY, PH_DONE: begin
      end
      default: begin
        cal_phase = PH_STANDBY;
      end
    endcase
    beat.phase            = cal_phase;
    beat.current_dac_code = sar_code;
    beat.comp_reset       = reset_pulse;
    beat.dff_code         = sweep_code;
    beat.current_offset   = current_cal;
    beat.dff_offset       = duty_cal;
    beat.save_request     = save;
    return beat;
  endfunction

  function automatic tick_t tick_of(logic start, int vp, int vm, logic relay, logic prech,
                                    int duty, int cnt);
    tick_t t;
    t.start_req      = start;
    t.vbus_plus      = 16'(vp);
    t.vbus_minus     = 16'(vm);
    t.relay_open     = relay;
    t.precharge_open = prech;
    t.duty_level     = 16'(duty);
    t.pwm_count      = 18'(cnt);
    return t;
  endfunction

  // A tick with healthy rails, a saturated duty most of the time and a PWM
  // count scattered around half the oversampled period.
  function automatic tick_t calibration_tick();
    tick_t  t;
    int     pick;
    longint half;
    longint cnt;
    t.start_req      = ($urandom_range(9) < 7);
    t.vbus_plus      = 16'($urandom_range(32767, int'(rail_min) + 1));
    t.vbus_minus     = 16'(-int'($urandom_range(32768, int'(rail_min) + 1)));
    t.relay_open     = 1'b1;
    t.precharge_open = 1'b1;
    pick = $urandom_range(99);
    if (pick < 45) begin
      t.duty_level = 16'($urandom_range(65535, 65537 - int'(sat_margin)));
    end else if (pick < 90) begin
      t.duty_level = 16'($urandom_range(int'(sat_margin) - 1, 0));
    end else begin
      t.duty_level = 16'($urandom_range(65536 - int'(sat_margin), int'(sat_margin)));
    end
    half = (longint'(period_top) + 1) * OVERSAMPLE / 2;
    cnt  = half + longint'($urandom_range(80000)) - 40000;
    if (cnt < 0) cnt = 0;
    if (cnt > 262143) cnt = 262143;
    t.pwm_count = 18'(cnt);
    return t;
  endfunction

  function automatic tick_t noise_tick();
    return tick_of($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endfunction

  // Spoils exactly the rail or relay check picked at random.
  function automatic tick_t with_failed_rails(tick_t t);
    case ($urandom_range(3))
      0: t.relay_open = 1'b0;
      1: t.precharge_open = 1'b0;
      2: t.vbus_plus = 16'($urandom_range(int'(rail_min)));
      default: t.vbus_minus = 16'(-int'($urandom_range(int'(rail_min))));
    endcase
    return t;
  endfunction

  // Presents one tick beat and records its expected result once accepted.
  task automatic send_tick(tick_t t);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    start_req      <= t.start_req;
    vbus_plus      <= t.vbus_plus;
    vbus_minus     <= t.vbus_minus;
    relay_open     <= t.relay_open;
    precharge_open <= t.precharge_open;
    duty_level     <= t.duty_level;
    pwm_count      <= t.pwm_count;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    expected_beats.push_back(advance_calibration(t));
    @(posedge clk);
  endtask

  // Holds the input idle until every expected beat has been checked.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_VBUS_MIN:    rail_min = data[14:0];
      CFG_DUTY_MARGIN: sat_margin = data;
      CFG_PWM_TOP:     period_top = data;
      CFG_DFF_START:   sweep_first = data[11:0];
      CFG_DFF_LAST:    sweep_last = data[11:0];
      default: begin
      end
    endcase
  endtask

  // Rail thresholds at both extremes, each failing check, and arming.
  task automatic test_rail_checks();
    wait_results_drained();
    write_reg(CFG_VBUS_MIN, 16'hFFFF);
    write_reg(CFG_PWM_TOP, 16'hFFFF);
    write_reg(CFG_DFF_START, 16'h0000);
    write_reg(CFG_DFF_LAST, 16'hFFFF);
    // Writes to indexes past the register list must leave everything alone.
    for (int i = CFG_DFF_LAST + 1; i < 2 ** CFG_INDEX_W; i++) begin
      write_reg(CFG_INDEX_W'(i), 16'($urandom));
    end
    send_tick(tick_of(1, 32767, -32768, 1, 1, 65535, 262143));
    wait_results_drained();
    write_reg(CFG_VBUS_MIN, 16'h0000);
    send_tick(tick_of(1, -32768, -1, 1, 1, 0, 0));
    send_tick(tick_of(1, 1, 32767, 1, 1, 0, 0));
    send_tick(tick_of(1, 1, -1, 0, 1, 0, 0));
    send_tick(tick_of(1, 1, -1, 1, 0, 0, 0));
    send_tick(tick_of(0, 32767, -32768, 1, 1, 0, 0));
    // Start request with healthy rails arms and starts the search at once.
    send_tick(tick_of(1, 32767, -32768, 1, 1, 0, 0));
  endtask

  // Single search steps: reset tick, hold, both saturation senses, margins.
  task automatic test_search_steps();
    send_tick(tick_of(1, 100, -100, 1, 1, 32768, 0));
    send_tick(tick_of(0, 100, -100, 1, 1, 32768, 0));
    send_tick(tick_of(0, 100, -100, 1, 1, 65535, 0));
    send_tick(tick_of(0, 100, -100, 1, 1, 65535, 0));
    send_tick(tick_of(0, 100, -100, 1, 1, 0, 0));
    send_tick(tick_of(0, 100, -100, 1, 1, 0, 0));
    wait_results_drained();
    // Widest margin: mid-scale duty reads as both saturations, high wins.
    write_reg(CFG_DUTY_MARGIN, 16'hFFFF);
    send_tick(tick_of(0, 100, -100, 1, 1, 32768, 0));
    // Rails fail while the compensator reset is pending; the flag stays.
    send_tick(tick_of(0, 100, -100, 0, 1, 32768, 0));
    wait_results_drained();
    // Zero margin: no duty reading ever saturates, the search holds.
    write_reg(CFG_DUTY_MARGIN, 16'h0000);
    send_tick(tick_of(1, 100, -100, 1, 1, 0, 0));
    send_tick(tick_of(0, 100, -100, 1, 1, 0, 0));
    send_tick(tick_of(0, 100, -100, 1, 1, 0, 0));
    send_tick(tick_of(0, 100, -100, 1, 1, 65535, 0));
    send_tick(tick_of(0, 100, -100, 1, 0, 65535, 0));
  endtask

  // Mostly well-formed calibration runs with random content, spoiled now and
  // then; a sweep is never allowed to finish since done holds until reset.
  task automatic test_random_sequences(int count, bit pause_midway);
    tick_t t;
    int    roll;
    bit    busy;
    int    first;
    wait_results_drained();
    write_reg(CFG_VBUS_MIN, 16'($urandom_range(20000)));
    write_reg(CFG_DUTY_MARGIN, 16'($urandom_range(30000, 1000)));
    write_reg(CFG_PWM_TOP, 16'($urandom));
    case ($urandom_range(2))
      0: first = 0;
      1: first = 4095 - 30;
      default: first = $urandom_range(4000);
    endcase
    write_reg(CFG_DFF_START, 16'(first));
    write_reg(CFG_DFF_LAST, 16'((first + 30 > 4095) ? 4095 : first + $urandom_range(30, 2)));
    for (int i = 0; i < count; i++) begin
      busy = (cal_phase == PH_SEARCH) || (cal_phase == PH_SWEEP);
      roll = $urandom_range(99);
      t = calibration_tick();
      if (roll < (busy ? 3 : 30)) begin
        t = (roll % 2 == 1) ? noise_tick() : with_failed_rails(t);
      end
      if (cal_phase == PH_SWEEP && (sweep_code + 13'd1) > {1'b0, sweep_last}) begin
        t = with_failed_rails(t);
      end
      if (pause_midway && i == count / 2) begin
        wait_results_drained();
      end
      send_tick(t);
    end
  endtask

  // One complete calibration with a sweep start past its last code, then
  // ticks that must all be ignored in the done phase.
  task automatic test_final_calibration();
    int guard;
    wait_results_drained();
    write_reg(CFG_PWM_TOP, 16'h0000);
    write_reg(CFG_DFF_START, 16'hFFFF);
    write_reg(CFG_DFF_LAST, 16'($urandom_range(4094)));
    guard = 0;
    while (cal_phase != PH_DONE && guard < 400) begin
      send_tick(calibration_tick());
      guard++;
    end
    repeat (4) send_tick(noise_tick());
    send_tick(with_failed_rails(calibration_tick()));
  endtask

  // Result side: random stall on the output channel.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < snk_idle_pct);
  end

  task automatic check_field(string field, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  // Each accepted result beat is compared with the oldest expectation.
  always @(negedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_beats.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with no expectation pending", $time);
      end else begin
        want = expected_beats.pop_front();
        check_field("phase", want.phase, phase);
        check_field("current_dac_code", want.current_dac_code, current_dac_code);
        check_field("comp_reset", want.comp_reset, comp_reset);
        check_field("dff_code", want.dff_code, dff_code);
        check_field("current_offset", want.current_offset, current_offset);
        check_field("dff_offset", want.dff_offset, dff_offset);
        check_field("save_request", want.save_request, save_request);
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("offset_autozero_sequencer verification failed");
      $finish;
    end
  end

  initial begin
    reset_calibration_model();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    src_idle_pct = 35;
    snk_idle_pct = 63;
    test_rail_checks();
    test_search_steps();
    test_random_sequences(165, 1'b0);
    src_idle_pct = 63;
    snk_idle_pct = 35;
    test_random_sequences(165, 1'b1);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random_sequences(165, 1'b0);
    test_final_calibration();
    wait_results_drained();
    if (mismatches == 0) begin
      $display("offset_autozero_sequencer verification clean");
    end else begin
      $display("offset_autozero_sequencer verification failed");
    end
    $finish;
  end

endmodule
